>>> rtl/core/tfs_pkg.sv
// Package for the tank filling sequencer: state and command codes,
// configuration register indexes, the threshold struct and default limits.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package tfs_pkg;

  localparam int unsigned SENSOR_W  = 16;
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned STATE_W   = 4;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [SENSOR_W-1:0] COPV_TARGET_PRESSURE_DEF = 16'd1000;
  localparam logic [SENSOR_W-1:0] POST_VENT_TRIGGER_DEF    = 16'd1000;
  localparam logic [SENSOR_W-1:0] POST_TARGET_PRESSURE_DEF = 16'd900;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE       = 4'd0,
    ST_ABORT      = 4'd1,
    ST_PAUSE_IDLE = 4'd2,
    ST_PAUSE_VENT = 4'd3,
    ST_COPV_IDLE  = 4'd4,
    ST_COPV_FILL  = 4'd5,
    ST_PRE_IDLE   = 4'd6,
    ST_PRE_VENT   = 4'd7,
    ST_PRE_FILL   = 4'd8,
    ST_N2O_IDLE   = 4'd9,
    ST_N2O_FILL   = 4'd10,
    ST_N2O_VENT   = 4'd11,
    ST_POST_IDLE  = 4'd12,
    ST_POST_VENT  = 4'd13,
    ST_POST_FILL  = 4'd14
  } state_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE      = 4'd0,
    CMD_HALT      = 4'd1,
    CMD_SCRUB     = 4'd2,
    CMD_HOLD      = 4'd3,
    CMD_COPV_FILL = 4'd4,
    CMD_PREPRESS  = 4'd5,
    CMD_FILL_N2O  = 4'd6,
    CMD_POSTPRESS = 4'd7,
    CMD_CLEAR     = 4'd8,
    CMD_CONTINUE  = 4'd9
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAUSE_VENT_TRIGGER     = 4'd0,
    REG_PAUSE_VENT_TARGET      = 4'd1,
    REG_PREPRESS_VENT_TRIGGER  = 4'd2,
    REG_PREPRESS_TARGET        = 4'd3,
    REG_OXIDIZER_TARGET_WEIGHT = 4'd4,
    REG_OXIDIZER_VENT_PRESSURE = 4'd5,
    REG_OXIDIZER_VENT_TEMP     = 4'd6,
    REG_OXIDIZER_RESUME_PRESS  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [SENSOR_W-1:0] pause_vent_trigger;
    logic        [SENSOR_W-1:0] pause_vent_target;
    logic        [SENSOR_W-1:0] prepress_vent_trigger;
    logic        [SENSOR_W-1:0] prepress_target;
    logic        [SENSOR_W-1:0] oxidizer_target_weight;
    logic        [SENSOR_W-1:0] oxidizer_vent_pressure;
    logic signed [SENSOR_W-1:0] oxidizer_vent_temp;
    logic        [SENSOR_W-1:0] oxidizer_resume_pressure;
  } thresh_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/tfs_if.sv
// Channel interfaces of the tank filling sequencer: sensor ticks in,
// state reports out, and the threshold register write channel.
// Depends on tfs_pkg for the field widths.
`default_nettype none

interface tfs_in_if
  import tfs_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic        [CMD_W-1:0]    command;
  logic        [SENSOR_W-1:0] nitrogen_pressure;
  logic        [SENSOR_W-1:0] oxidizer_pressure;
  logic        [SENSOR_W-1:0] oxidizer_weight;
  logic signed [SENSOR_W-1:0] temperature;

  modport source (
    output valid, command, nitrogen_pressure, oxidizer_pressure,
           oxidizer_weight, temperature,
    input  ready
  );
  modport sink (
    input  valid, command, nitrogen_pressure, oxidizer_pressure,
           oxidizer_weight, temperature,
    output ready
  );
endinterface

interface tfs_out_if
  import tfs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] current_state;
  logic               changed;

  modport source (output valid, current_state, changed, input ready);
  modport sink (input valid, current_state, changed, output ready);
endinterface

interface tfs_cfg_if
  import tfs_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SENSOR_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tfs_next_state.sv
// Transition logic of the filling sequence: global commands, mode entry
// from idle, clear and continue, and the per-leaf threshold checks.
// Purely combinational. Depends on tfs_pkg.
`default_nettype none

module tfs_next_state
  import tfs_pkg::*;
#(
  parameter logic [SENSOR_W-1:0] COPV_TARGET_PRESSURE = COPV_TARGET_PRESSURE_DEF,
  parameter logic [SENSOR_W-1:0] POST_VENT_TRIGGER    = POST_VENT_TRIGGER_DEF,
  parameter logic [SENSOR_W-1:0] POST_TARGET_PRESSURE = POST_TARGET_PRESSURE_DEF
) (
  input  state_t                     state,
  input  logic        [CMD_W-1:0]    command,
  input  logic        [SENSOR_W-1:0] nitrogen_pressure,
  input  logic        [SENSOR_W-1:0] oxidizer_pressure,
  input  logic        [SENSOR_W-1:0] oxidizer_weight,
  input  logic signed [SENSOR_W-1:0] temperature,
  input  thresh_cfg_t                cfg,
  output state_t                     nxt_state,
  output logic                       moved
);

  logic signed [SENSOR_W-1:0] vent_temp;

  assign vent_temp = cfg.oxidizer_vent_temp;

  always_comb begin
    nxt_state = state;
    moved     = 1'b0;
    priority if (command == CMD_HALT) begin
      nxt_state = ST_IDLE;
      moved     = 1'b1;
    end else if (command == CMD_SCRUB) begin
      nxt_state = ST_ABORT;
      moved     = 1'b1;
    end else if (command == CMD_HOLD) begin
      nxt_state = ST_PAUSE_IDLE;
      moved     = 1'b1;
    end else begin
      unique case (state)
        ST_ABORT: begin
          if (command == CMD_CLEAR) begin
            nxt_state = ST_IDLE;
            moved     = 1'b1;
          end
        end
        // In pause the leaf check wins; resume applies only when it did not fire.
        ST_PAUSE_IDLE: begin
          if (nitrogen_pressure > cfg.pause_vent_trigger) begin
            nxt_state = ST_PAUSE_VENT;
            moved     = 1'b1;
          end else if (command == CMD_CONTINUE) begin
            nxt_state = ST_IDLE;
            moved     = 1'b1;
          end
        end
        ST_PAUSE_VENT: begin
          if (nitrogen_pressure <= cfg.pause_vent_target) begin
            nxt_state = ST_PAUSE_IDLE;
            moved     = 1'b1;
          end else if (command == CMD_CONTINUE) begin
            nxt_state = ST_IDLE;
            moved     = 1'b1;
          end
        end
        ST_COPV_IDLE: begin
          if (nitrogen_pressure <= COPV_TARGET_PRESSURE) begin
            nxt_state = ST_COPV_FILL;
            moved     = 1'b1;
          end
        end
        ST_COPV_FILL: begin
          if (nitrogen_pressure >= COPV_TARGET_PRESSURE) begin
            nxt_state = ST_COPV_IDLE;
            moved     = 1'b1;
          end
        end
        ST_PRE_IDLE: begin
          if (nitrogen_pressure > cfg.prepress_vent_trigger) begin
            nxt_state = ST_PRE_VENT;
            moved     = 1'b1;
          end else if (oxidizer_pressure < cfg.prepress_target) begin
            nxt_state = ST_PRE_FILL;
            moved     = 1'b1;
          end
        end
        // The vent exit compares nitrogen pressure against the N2O target.
        ST_PRE_VENT: begin
          if (nitrogen_pressure <= cfg.prepress_target) begin
            nxt_state = ST_PRE_IDLE;
            moved     = 1'b1;
          end
        end
        ST_PRE_FILL: begin
          if (oxidizer_pressure >= cfg.prepress_target) begin
            nxt_state = ST_PRE_IDLE;
            moved     = 1'b1;
          end
        end
        ST_N2O_IDLE: begin
          if (oxidizer_weight < cfg.oxidizer_target_weight) begin
            nxt_state = ST_N2O_FILL;
            moved     = 1'b1;
          end
        end
        ST_N2O_FILL: begin
          if (oxidizer_pressure >= cfg.oxidizer_vent_pressure &&
              temperature > vent_temp) begin
            nxt_state = ST_N2O_VENT;
            moved     = 1'b1;
          end else if (oxidizer_weight >= cfg.oxidizer_target_weight) begin
            nxt_state = ST_N2O_IDLE;
            moved     = 1'b1;
          end
        end
        ST_N2O_VENT: begin
          if (oxidizer_pressure <= cfg.oxidizer_resume_pressure ||
              temperature <= vent_temp) begin
            nxt_state = ST_N2O_FILL;
            moved     = 1'b1;
          end
        end
        ST_POST_IDLE: begin
          if (nitrogen_pressure > POST_VENT_TRIGGER) begin
            nxt_state = ST_POST_VENT;
            moved     = 1'b1;
          end else if (oxidizer_pressure < POST_TARGET_PRESSURE) begin
            nxt_state = ST_POST_FILL;
            moved     = 1'b1;
          end
        end
        ST_POST_VENT: begin
          if (nitrogen_pressure <= POST_TARGET_PRESSURE) begin
            nxt_state = ST_POST_IDLE;
            moved     = 1'b1;
          end
        end
        ST_POST_FILL: begin
          if (oxidizer_pressure >= POST_TARGET_PRESSURE) begin
            nxt_state = ST_POST_IDLE;
            moved     = 1'b1;
          end
        end
        default: begin
          // Top-level idle: a mode command enters that mode's idle child.
          if (command == CMD_COPV_FILL) begin
            nxt_state = ST_COPV_IDLE;
            moved     = 1'b1;
          end else if (command == CMD_PREPRESS) begin
            nxt_state = ST_PRE_IDLE;
            moved     = 1'b1;
          end else if (command == CMD_FILL_N2O) begin
            nxt_state = ST_N2O_IDLE;
            moved     = 1'b1;
          end else if (command == CMD_POSTPRESS) begin
            nxt_state = ST_POST_IDLE;
            moved     = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tank_filling_sequencer.sv
// Tank filling sequencer.
// Each item on the input channel is one sensor tick: a command code and the
// nitrogen pressure, N2O pressure, N2O weight and temperature readings. For
// every item accepted, exactly one item leaves on the result channel: the
// leaf state after the tick and a flag that is set when a transition was taken.
// Thresholds are written over the configuration channel, which is always
// ready; write only while no tick is in flight.
// An accepted item passes the input register and then the result register;
// the state update between the two is combinational. Throughput: one item
// per cycle while the receiver takes the results.
// When the receiver stalls, the held result and one registered tick wait;
// in_ch.ready drops only when both registers are full and out_ch.ready is low.
// Reset (rst_n low, synchronous) empties both registers, returns the leaf
// state to idle and clears all thresholds to zero.
// Depends on tfs_pkg, the channel interfaces in tfs_if and tfs_next_state.
`default_nettype none

module tank_filling_sequencer
  import tfs_pkg::*;
#(
  parameter logic [SENSOR_W-1:0] COPV_TARGET_PRESSURE = COPV_TARGET_PRESSURE_DEF,
  parameter logic [SENSOR_W-1:0] POST_VENT_TRIGGER    = POST_VENT_TRIGGER_DEF,
  parameter logic [SENSOR_W-1:0] POST_TARGET_PRESSURE = POST_TARGET_PRESSURE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tfs_in_if.sink    in_ch,
  tfs_out_if.source out_ch,
  tfs_cfg_if.sink   cfg_ch
);

  // Threshold registers.
  thresh_cfg_t cfg_r;
  thresh_cfg_t cfg_nxt;

  // Input register stage.
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic        [CMD_W-1:0]    cmd_r;
  logic        [SENSOR_W-1:0] np_r;
  logic        [SENSOR_W-1:0] op_r;
  logic        [SENSOR_W-1:0] ow_r;
  logic signed [SENSOR_W-1:0] temp_r;

  // Sequence state and result register.
  state_t             leaf_state_r;
  state_t             leaf_state_nxt;
  logic               moved;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [STATE_W-1:0] out_state_r;
  logic [STATE_W-1:0] out_state_nxt;
  logic               out_changed_r;
  logic               out_changed_nxt;

  logic in_accept;
  logic out_free;
  logic s1_adv;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = !s1_valid_r || out_free;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.current_state = out_state_r;
  assign out_ch.changed       = out_changed_r;
  assign cfg_ch.ready         = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PAUSE_VENT_TRIGGER:     cfg_nxt.pause_vent_trigger       = cfg_ch.data;
        REG_PAUSE_VENT_TARGET:      cfg_nxt.pause_vent_target        = cfg_ch.data;
        REG_PREPRESS_VENT_TRIGGER:  cfg_nxt.prepress_vent_trigger    = cfg_ch.data;
        REG_PREPRESS_TARGET:        cfg_nxt.prepress_target          = cfg_ch.data;
        REG_OXIDIZER_TARGET_WEIGHT: cfg_nxt.oxidizer_target_weight   = cfg_ch.data;
        REG_OXIDIZER_VENT_PRESSURE: cfg_nxt.oxidizer_vent_pressure   = cfg_ch.data;
        REG_OXIDIZER_VENT_TEMP:     cfg_nxt.oxidizer_vent_temp       = cfg_ch.data;
        REG_OXIDIZER_RESUME_PRESS:  cfg_nxt.oxidizer_resume_pressure = cfg_ch.data;
        default: ;
      endcase
    end
  end

  tfs_next_state #(
    .COPV_TARGET_PRESSURE (COPV_TARGET_PRESSURE),
    .POST_VENT_TRIGGER    (POST_VENT_TRIGGER),
    .POST_TARGET_PRESSURE (POST_TARGET_PRESSURE)
  ) u_next_state (
    .state             (leaf_state_r),
    .command           (cmd_r),
    .nitrogen_pressure (np_r),
    .oxidizer_pressure (op_r),
    .oxidizer_weight   (ow_r),
    .temperature       (temp_r),
    .cfg               (cfg_r),
    .nxt_state         (leaf_state_nxt),
    .moved             (moved)
  );

  // Valid flags of both stages.
  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Result payload: the new leaf and the transition flag.
  always_comb begin
    out_state_nxt   = out_state_r;
    out_changed_nxt = out_changed_r;
    if (s1_adv) begin
      out_state_nxt   = leaf_state_nxt;
      out_changed_nxt = moved;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      leaf_state_r <= ST_IDLE;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        leaf_state_r <= leaf_state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_ch.command;
      np_r   <= in_ch.nitrogen_pressure;
      op_r   <= in_ch.oxidizer_pressure;
      ow_r   <= in_ch.oxidizer_weight;
      temp_r <= in_ch.temperature;
    end
    out_state_r   <= out_state_nxt;
    out_changed_r <= out_changed_nxt;
  end

  // The reported state is the leaf state that the same tick left behind.
  a_report_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_state_r == leaf_state_r))
    else $error("reported state differs from the held leaf state");

  // The leaf state moves only when a tick is handed to the result register.
  a_state_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(leaf_state_r))
    else $error("leaf state changed without a tick");

  // A tick that reports no transition leaves the state as it was.
  a_no_move_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !moved) |=> (leaf_state_r == $past(leaf_state_r)))
    else $error("state changed on a tick flagged as no transition");

  // Stop wins over every threshold check.
  a_stop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && cmd_r == CMD_HALT) |=> (leaf_state_r == ST_IDLE && out_changed_r))
    else $error("stop did not return to idle");

endmodule

`default_nettype wire
